>>> design/sfr_pkg.sv
// shared types and constants for the sbus frame receiver
// no dependencies; imported by sfr_ctrl, sfr_datapath and sbus_frame_receiver_unit
package sfr_pkg;

    localparam int FRAME_LEN  = 25;
    localparam int FRAME_BITS = FRAME_LEN * 8;
    localparam int POS_W      = 5;
    localparam int CH_W       = 5;
    localparam int RAW_W      = 11;
    localparam int US_W       = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FOOTER      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PACKET_TOUT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LINK_TOUT   = 2'd3;

    localparam logic [7:0]  HEADER_RST      = 8'd15;
    localparam logic [7:0]  FOOTER_RST      = 8'd0;
    localparam logic [7:0]  PACKET_TOUT_RST = 8'd3;
    localparam logic [15:0] LINK_TOUT_RST   = 16'd100;

    // input kinds and result kinds
    localparam logic KIND_BYTE        = 1'b0;
    localparam logic KIND_TICK        = 1'b1;
    localparam logic RESULT_CHANNEL   = 1'b0;
    localparam logic RESULT_LINK_LOST = 1'b1;

    // frame layout
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);
    localparam logic [CH_W-1:0]  CH_DIG0    = 5'd16;
    localparam logic [CH_W-1:0]  CH_DIG1    = 5'd17;
    localparam int               FLAG_DIG0  = 0;
    localparam int               FLAG_DIG1  = 1;
    localparam int               FLAG_LOST  = 2;
    localparam int               FLAG_FSAFE = 3;

    // raw to microsecond mapping: (raw - 172) * 1000 / 1639 + 1000, clamped
    localparam logic [RAW_W-1:0] RAW_MIN     = 11'd172;
    localparam logic [US_W-1:0]  US_MIN      = 11'd1000;
    localparam logic [US_W-1:0]  US_MAX      = 11'd2000;
    localparam int               NUM_W       = 21;
    localparam int               US_SPAN     = 1000;
    localparam int               RAW_SPAN    = 1639;
    localparam int               RECIP_SHIFT = 32;
    localparam int               RECIP       = 2620480;   // floor(2^32 / 1639)
    localparam int               PROD_W      = 43;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP1,
        ST_MAP2,
        ST_MAP3
    } t_state;

    typedef struct packed {
        logic accept;       // input beat taken this cycle
        logic load_status;  // load link lost result into output register
        logic stage1;       // raw channel to scaled numerator
        logic stage2;       // reciprocal multiply
        logic load_chan;    // correct, clamp and load channel result
        logic next_ch;      // advance to the next channel
    } t_cmd;

    typedef struct packed {
        logic good_frame;   // current byte completes a frame with a valid footer
        logic lost_event;   // current tick enters the link lost state
        logic last_chan;    // channel under work is the final one
    } t_sts;

endpackage

>>> design/sfr_ctrl.sv
// controller state machine for the sbus frame receiver
// depends on sfr_pkg; drives sfr_datapath through t_cmd and reads t_sts
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && w_out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.lost_event) begin
                        o_cmd.load_status = 1'b1;
                        n_out_valid       = 1'b1;
                    end
                    if (i_sts.good_frame) begin
                        n_state = ST_MAP1;
                    end
                end
            end
            ST_MAP1: begin
                o_cmd.stage1 = 1'b1;
                n_state      = ST_MAP2;
            end
            ST_MAP2: begin
                o_cmd.stage2 = 1'b1;
                n_state      = ST_MAP3;
            end
            ST_MAP3: begin
                // hold the finished value until the output register frees up
                if (w_out_free) begin
                    o_cmd.load_chan = 1'b1;
                    n_out_valid     = 1'b1;
                    if (i_sts.last_chan) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_ch = 1'b1;
                        n_state       = ST_MAP1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/sfr_datapath.sv
// datapath for the sbus frame receiver: config registers, frame shift register,
// timers, link flags, channel scaling and the output register; depends on sfr_pkg
module sfr_datapath
    import sfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_kind,
    input  logic [7:0]            i_byte,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_kind,
    output logic [CH_W-1:0]       o_ch,
    output logic [US_W-1:0]       o_us,
    output logic                  o_fs,
    output logic                  o_lost,
    output logic                  o_conn,
    output logic                  o_last
);

    // configuration
    logic [7:0]  r_header, r_footer, r_pkt_tout;
    logic [15:0] r_link_tout;

    // receive state
    logic [FRAME_BITS-1:0] r_frame;
    logic [POS_W-1:0]      r_pos;
    logic [7:0]            r_idle;
    logic [15:0]           r_age;
    logic                  r_link_up, r_fs, r_lost;
    logic [1:0]            r_dig;
    logic [CH_W-1:0]       r_ch;

    // scaling pipeline
    logic                  r_low;
    logic [NUM_W-1:0]      r_num;
    logic [US_W-1:0]       r_q;

    // output register
    logic                  r_o_kind, r_o_fs, r_o_lost, r_o_conn, r_o_last;
    logic [CH_W-1:0]       r_o_ch;
    logic [US_W-1:0]       r_o_us;

    logic                  w_store, w_good, w_lost_evt, w_was_lost;
    logic [7:0]            n_idle;
    logic [15:0]           n_age;
    logic [7:0]            w_flags;
    logic [RAW_W-1:0]      w_raw, w_diff;
    logic [PROD_W-1:0]     w_prod;
    logic [US_W:0]         w_q1;
    logic [NUM_W-1:0]      w_back;
    logic [US_W-1:0]       w_qfix;
    logic [US_W:0]         w_sum;
    logic [US_W-1:0]       w_us;

    assign w_store    = !((r_pos == '0) && (i_byte != r_header));
    assign w_good     = (i_kind == KIND_BYTE) && w_store && (r_pos == POS_LAST)
                        && (i_byte == r_footer);
    assign n_idle     = (r_idle == 8'hFF) ? r_idle : r_idle + 8'd1;
    assign n_age      = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;
    assign w_was_lost = !r_link_up && r_fs;
    assign w_lost_evt = (i_kind == KIND_TICK) && (n_age > r_link_tout) && !w_was_lost;
    // byte 23 sits at the top of the shift register when byte 24 arrives
    assign w_flags    = r_frame[FRAME_BITS-1 -: 8];

    assign o_sts.good_frame = w_good;
    assign o_sts.lost_event = w_lost_evt;
    assign o_sts.last_chan  = (r_ch == CH_DIG1);

    // channel 0 starts at bit 8 (byte 1); the register shifts by 11 per channel
    assign w_raw  = r_frame[8 +: RAW_W];
    assign w_diff = w_raw - RAW_MIN;
    assign w_prod = PROD_W'(r_num) * PROD_W'(RECIP);

    // quotient estimate is exact or one low
    assign w_q1   = {1'b0, r_q} + 12'd1;
    assign w_back = NUM_W'(w_q1) * NUM_W'(RAW_SPAN);
    assign w_qfix = (w_back <= r_num) ? w_q1[US_W-1:0] : r_q;
    assign w_sum  = {1'b0, w_qfix} + {1'b0, US_MIN};

    always_comb begin
        if (r_ch == CH_DIG0) begin
            w_us = r_dig[0] ? US_MAX : US_MIN;
        end else if (r_ch == CH_DIG1) begin
            w_us = r_dig[1] ? US_MAX : US_MIN;
        end else if (r_low) begin
            w_us = US_MIN;
        end else if (w_sum > {1'b0, US_MAX}) begin
            w_us = US_MAX;
        end else begin
            w_us = w_sum[US_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= HEADER_RST;
            r_footer    <= FOOTER_RST;
            r_pkt_tout  <= PACKET_TOUT_RST;
            r_link_tout <= LINK_TOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_HEADER:      r_header    <= i_cfg_wdata[7:0];
                REG_FOOTER:      r_footer    <= i_cfg_wdata[7:0];
                REG_PACKET_TOUT: r_pkt_tout  <= i_cfg_wdata[7:0];
                REG_LINK_TOUT:   r_link_tout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_idle    <= '0;
            r_age     <= '0;
            r_link_up <= 1'b0;
            r_fs      <= 1'b0;
            r_lost    <= 1'b0;
            r_ch      <= '0;
        end else if (i_cmd.accept) begin
            if (i_kind == KIND_BYTE) begin
                r_idle <= '0;
                if (w_store) begin
                    r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + 5'd1;
                end
                if (w_good) begin
                    r_fs      <= w_flags[FLAG_FSAFE];
                    r_lost    <= w_flags[FLAG_LOST];
                    r_link_up <= 1'b1;
                    r_age     <= '0;
                    r_ch      <= '0;
                end
            end else begin
                r_idle <= n_idle;
                r_age  <= n_age;
                if ((n_idle > r_pkt_tout) && (r_pos != '0)) begin
                    r_pos <= '0;
                end
                if (n_age > r_link_tout) begin
                    r_link_up <= 1'b0;
                    r_fs      <= 1'b1;
                end
            end
        end else if (i_cmd.next_ch) begin
            r_ch <= r_ch + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_kind == KIND_BYTE) && w_store) begin
            r_frame <= {i_byte, r_frame[FRAME_BITS-1:8]};
            if (w_good) begin
                r_dig <= {w_flags[FLAG_DIG1], w_flags[FLAG_DIG0]};
            end
        end else if (i_cmd.next_ch) begin
            r_frame <= {{RAW_W{1'b0}}, r_frame[FRAME_BITS-1:RAW_W]};
        end
        if (i_cmd.stage1) begin
            r_low <= (w_raw <= RAW_MIN);
            r_num <= NUM_W'(w_diff) * NUM_W'(US_SPAN);
        end
        if (i_cmd.stage2) begin
            r_q <= w_prod[RECIP_SHIFT +: US_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_status) begin
            r_o_kind <= RESULT_LINK_LOST;
            r_o_ch   <= '0;
            r_o_us   <= '0;
            r_o_fs   <= 1'b1;
            r_o_lost <= r_lost;
            r_o_conn <= 1'b0;
            r_o_last <= 1'b1;
        end else if (i_cmd.load_chan) begin
            r_o_kind <= RESULT_CHANNEL;
            r_o_ch   <= r_ch;
            r_o_us   <= w_us;
            r_o_fs   <= r_fs;
            r_o_lost <= r_lost;
            r_o_conn <= 1'b1;
            r_o_last <= (r_ch == CH_DIG1);
        end
    end

    assign o_kind = r_o_kind;
    assign o_ch   = r_o_ch;
    assign o_us   = r_o_us;
    assign o_fs   = r_o_fs;
    assign o_lost = r_o_lost;
    assign o_conn = r_o_conn;
    assign o_last = r_o_last;

endmodule

>>> design/sbus_frame_receiver_unit.sv
// top level of the sbus frame receiver: joins sfr_ctrl and sfr_datapath
// depends on sfr_pkg, sfr_ctrl and sfr_datapath
//
// usage:
// - slave stream: s_axis_tuser is the beat kind (0 = received byte, 1 = 1 ms tick),
//   s_axis_tdata[7:0] the byte. the master stream carries channel results and the
//   link lost status; m_axis_tlast marks the final result of a run.
// - config port: i_cfg_we writes i_cfg_wdata into the register at i_cfg_addr
//   (0 header, 1 footer, 2 packet timeout, 3 link timeout); write only while idle.
// - a byte or tick that produces nothing leaves the block in its idle state.
// - a tick that loses the link loads the status result at its accept edge; the same
//   edge raises m_axis_tvalid.
// - a byte that closes a good frame starts the decode: each of the 18 channels runs
//   through three steps of the shared scaling unit (multiply by 1000, reciprocal
//   multiply, correct and clamp), one channel after another; a finished channel waits
//   in the last step while the sink stalls. s_axis_tready is low during the decode.
// - a stalled sink holds the output register; the block waits with it.
// - reset restores the register defaults, empties the frame and clears the link.
module sbus_frame_receiver_unit
    import sfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] byte_value
    input  logic                  s_axis_tuser,   // [0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] channel_index, [15:5] value_us, [16] failsafe, [17] lost_frame,
    // [18] connected, [23:19] zero
    output logic [23:0]           m_axis_tdata,
    output logic                  m_axis_tuser,   // [0] result_kind
    output logic                  m_axis_tlast
);

    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [CH_W-1:0] w_ch;
    logic [US_W-1:0] w_us;
    logic            w_fs, w_lost, w_conn;

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    sfr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_kind      (m_axis_tuser),
        .o_ch        (w_ch),
        .o_us        (w_us),
        .o_fs        (w_fs),
        .o_lost      (w_lost),
        .o_conn      (w_conn),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, w_conn, w_lost, w_fs, w_us, w_ch};

endmodule

>>> tb/sbus_frame_receiver_unit_tb.sv
// self-checking testbench for sbus_frame_receiver_unit: byte/tick stream in, decoded channels out
// depends on sfr_pkg and the rtl under design/; predicts results in a small scoreboard class
`timescale 1ns / 1ps

module sbus_frame_receiver_unit_tb
    import sfr_pkg::*;
;

    localparam int FLAGS_POS      = 23;
    localparam int ANALOG_CH      = 16;
    localparam int NUM_CH         = 18;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    // packed so that the low 24 bits line up with m_axis_tdata
    typedef struct packed {
        logic        kind;
        logic        last;
        logic [4:0]  pad;
        logic        connected;
        logic        lost_frame;
        logic        failsafe;
        logic [10:0] value_us;
        logic [4:0]  channel;
    } t_sfr_result;

    class t_sfr_scoreboard;
        logic [7:0]  hdr;
        logic [7:0]  ftr;
        logic [7:0]  pkt_tout;
        logic [15:0] link_tout;
        logic [7:0]  frame [FRAME_LEN];
        int          pos;
        logic [7:0]  idle_ms;
        logic [15:0] link_age;
        logic        link_up;
        logic        fsafe;
        logic        lost;
        t_sfr_result expected_results [$];
        int          mismatches;

        function new();
            hdr        = HEADER_RST;
            ftr        = FOOTER_RST;
            pkt_tout   = PACKET_TOUT_RST;
            link_tout  = LINK_TOUT_RST;
            pos        = 0;
            idle_ms    = '0;
            link_age   = '0;
            link_up    = 1'b0;
            fsafe      = 1'b0;
            lost       = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_HEADER:      hdr       = val[7:0];
                REG_FOOTER:      ftr       = val[7:0];
                REG_PACKET_TOUT: pkt_tout  = val[7:0];
                REG_LINK_TOUT:   link_tout = val;
                default: ;
            endcase
        endfunction

        function logic [10:0] raw_to_us(int unsigned raw);
            int unsigned v;
            if (raw <= RAW_MIN) return US_MIN;
            v = (raw - RAW_MIN) * US_SPAN / RAW_SPAN + US_MIN;
            if (v > US_MAX) return US_MAX;
            return v[10:0];
        endfunction

        // 11-bit channels packed little-endian from byte 1
        function int unsigned frame_channel(int ch);
            int unsigned bitpos;
            int unsigned b;
            logic [23:0] w;
            bitpos = 11 * ch;
            b      = 1 + bitpos / 8;
            w      = {frame[b+2], frame[b+1], frame[b]};
            return 32'((w >> (bitpos % 8)) & 24'h7FF);
        endfunction

        function void note_beat(logic kind, logic [7:0] b);
            logic [7:0]  flags;
            logic        was_lost;
            t_sfr_result r;
            if (kind == KIND_BYTE) begin
                idle_ms = '0;
                if (pos == 0 && b != hdr) return;
                frame[pos] = b;
                pos++;
                if (pos < FRAME_LEN) return;
                pos = 0;
                if (frame[FRAME_LEN-1] != ftr) return;
                flags    = frame[FLAGS_POS];
                fsafe    = flags[FLAG_FSAFE];
                lost     = flags[FLAG_LOST];
                link_up  = 1'b1;
                link_age = '0;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r            = '0;
                    r.kind       = RESULT_CHANNEL;
                    r.channel    = 5'(ch);
                    r.failsafe   = fsafe;
                    r.lost_frame = lost;
                    r.connected  = 1'b1;
                    r.last       = (ch == NUM_CH - 1);
                    if (ch < ANALOG_CH)
                        r.value_us = raw_to_us(frame_channel(ch));
                    else if (flags[(ch == ANALOG_CH) ? FLAG_DIG0 : FLAG_DIG1])
                        r.value_us = US_MAX;
                    else
                        r.value_us = US_MIN;
                    expected_results.push_back(r);
                end
            end else begin
                if (idle_ms != 8'hFF) idle_ms++;
                if (idle_ms > pkt_tout && pos != 0) pos = 0;
                if (link_age != 16'hFFFF) link_age++;
                if (link_age > link_tout) begin
                    was_lost = !link_up && fsafe;
                    link_up  = 1'b0;
                    fsafe    = 1'b1;
                    // status goes out only on entry to the lost state
                    if (!was_lost) begin
                        r            = '0;
                        r.kind       = RESULT_LINK_LOST;
                        r.failsafe   = 1'b1;
                        r.lost_frame = lost;
                        r.last       = 1'b1;
                        expected_results.push_back(r);
                    end
                end
            end
        endfunction

        function void cmp(string what, int unsigned exp_v, int unsigned got_v, int unsigned ch);
            if (exp_v != got_v) begin
                mismatches++;
                $display("%0t: channel %0d %s mismatch: expected %0d, actual %0d",
                         $time, ch, what, exp_v, got_v);
            end
        endfunction

        function void check_result(logic kind, logic [23:0] data, logic last);
            t_sfr_result got_r;
            t_sfr_result exp_r;
            got_r = {kind, last, data};
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual kind %0d data %h last %0d",
                         $time, kind, data, last);
                return;
            end
            exp_r = expected_results.pop_front();
            cmp("kind",       exp_r.kind,       got_r.kind,       exp_r.channel);
            cmp("index",      exp_r.channel,    got_r.channel,    exp_r.channel);
            cmp("value_us",   exp_r.value_us,   got_r.value_us,   exp_r.channel);
            cmp("failsafe",   exp_r.failsafe,   got_r.failsafe,   exp_r.channel);
            cmp("lost_frame", exp_r.lost_frame, got_r.lost_frame, exp_r.channel);
            cmp("connected",  exp_r.connected,  got_r.connected,  exp_r.channel);
            cmp("pad",        exp_r.pad,        got_r.pad,        exp_r.channel);
            cmp("tlast",      exp_r.last,       got_r.last,       exp_r.channel);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    t_sfr_scoreboard sb;
    int              src_idle_pct = 0;
    int              rx_stall_pct = 0;
    logic            rx_hold      = 1'b0;
    int              beat_count   = 0;
    int              quiet_cycles = 0;
    logic [7:0]      tx_frame [FRAME_LEN];

    int unsigned edge_raws [16] = '{0, 1, 171, 172, 173, 174, 992, 1024,
                                    1810, 1811, 1812, 1813, 2046, 2047, 1500, 600};
    int unsigned top_raws  [16] = '{default: 2047};

    sbus_frame_receiver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("sbus_frame_receiver_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_beat(input logic kind, input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(kind, b);
        beat_count++;
        @(negedge i_clk);
    endtask

    task automatic ticks(input int n);
        repeat (n) put_beat(KIND_TICK, 8'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] hdr, input logic [7:0] ftr,
                             input logic [7:0] pkt, input logic [15:0] link,
                             input logic [7:0] junk);
        logic [CFG_ADDR_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{REG_HEADER, REG_FOOTER, REG_PACKET_TOUT, REG_LINK_TOUT};
        val = '{{junk, hdr}, {junk, ftr}, {junk, pkt}, link};
        wait_drained();
        // a beat that produced nothing may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        foreach (idx[i]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[i];
            i_cfg_wdata <= val[i];
            @(negedge i_clk);
            sb.set_reg(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic pack_raw_frame(input int unsigned raws [16], input logic [7:0] flags);
        int p;
        tx_frame[0] = sb.hdr;
        for (int i = 1; i < FLAGS_POS; i++) tx_frame[i] = '0;
        for (int ch = 0; ch < ANALOG_CH; ch++) begin
            for (int k = 0; k < 11; k++) begin
                p = 8 + 11 * ch + k;
                tx_frame[p / 8][p % 8] = raws[ch][k];
            end
        end
        tx_frame[FLAGS_POS]     = flags;
        tx_frame[FRAME_LEN - 1] = sb.ftr;
    endtask

    task automatic random_frame(input bit good);
        tx_frame[0] = sb.hdr;
        for (int i = 1; i < FRAME_LEN - 1; i++) tx_frame[i] = 8'($urandom);
        tx_frame[FRAME_LEN - 1] = good ? sb.ftr : sb.ftr ^ 8'($urandom_range(1, 255));
    endtask

    // short tick runs inside a frame stay within the packet timeout
    task automatic send_frame(input int first, input int count, input bit with_ticks);
        for (int i = first; i < first + count; i++) begin
            if (with_ticks && i > first && $urandom_range(0, 99) < 10)
                ticks($urandom_range(1, int'(sb.pkt_tout)));
            put_beat(KIND_BYTE, tx_frame[i]);
        end
    endtask

    task automatic run_random(input int n_items);
        int start;
        int sel;
        start = beat_count;
        while (beat_count - start < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                random_frame(1'b1);
                send_frame(0, FRAME_LEN, 1'b1);
            end else if (sel < 70) begin
                random_frame(1'b0);
                send_frame(0, FRAME_LEN, 1'b1);
            end else if (sel < 80) begin
                random_frame(1'b1);
                send_frame(0, $urandom_range(1, FRAME_LEN - 1), 1'b0);
                ticks(int'(sb.pkt_tout) + 1);
            end else if (sel < 90) begin
                ticks($urandom_range(1, int'(sb.link_tout) + 5));
            end else begin
                repeat ($urandom_range(1, 5)) put_beat(KIND_BYTE, 8'($urandom));
                if ($urandom_range(0, 1)) ticks(int'(sb.pkt_tout) + 1);
            end
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_BYTE;
        m_axis_tready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults after reset; non-header bytes are dropped
        put_beat(KIND_BYTE, 8'h00);
        put_beat(KIND_BYTE, 8'hFF);
        put_beat(KIND_BYTE, 8'h0E);
        ticks(2);
        pack_raw_frame(edge_raws, 8'h00);
        send_frame(0, FRAME_LEN, 1'b0);
        pack_raw_frame(top_raws, 8'h0F);
        send_frame(0, FRAME_LEN, 1'b0);
        // bad footer is discarded silently
        random_frame(1'b0);
        tx_frame[FLAGS_POS] = 8'h05;
        send_frame(0, FRAME_LEN, 1'b0);
        // partial frame dropped after idle passes the packet timeout
        random_frame(1'b1);
        send_frame(0, 10, 1'b0);
        ticks(int'(sb.pkt_tout) + 1);
        random_frame(1'b1);
        tx_frame[FLAGS_POS] = 8'h0A;
        send_frame(0, FRAME_LEN, 1'b0);
        // idle equal to the timeout keeps the partial frame
        random_frame(1'b1);
        send_frame(0, 10, 1'b0);
        ticks(int'(sb.pkt_tout));
        send_frame(10, FRAME_LEN - 10, 1'b0);
        // link loss: one status, then silence while lost
        ticks(int'(sb.link_tout) + 1);
        ticks(5);

        // zero timeouts act after the first tick
        configure(8'h00, 8'hFF, 8'h00, 16'h0000, 8'hA5);
        random_frame(1'b1);
        send_frame(0, 10, 1'b0);
        ticks(1);
        random_frame(1'b1);
        send_frame(0, FRAME_LEN, 1'b0);
        ticks(1);
        ticks(3);
        put_beat(KIND_BYTE, 8'h00);
        ticks(1);

        // largest timeouts keep a partial frame across idle ticks
        configure(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 8'h5A);
        random_frame(1'b1);
        send_frame(0, 12, 1'b0);
        ticks(4);
        send_frame(12, FRAME_LEN - 12, 1'b0);

        // random traffic under the four idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            configure(8'($urandom), 8'($urandom), 8'($urandom_range(1, 12)),
                      16'($urandom_range(10, 80)), 8'($urandom));
            case (ph)
                0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin src_idle_pct = 59; rx_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin src_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            run_random(10);
            if (ph == 0) begin
                // sink holds off while frames keep coming, so the input backs up
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
                repeat (2) begin
                    random_frame(1'b1);
                    send_frame(0, FRAME_LEN, 1'b0);
                end
                wait_drained();
                repeat (20) @(negedge i_clk);
            end
        end

        wait_drained();
        repeat (100) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("sbus_frame_receiver_unit regression: pass");
        else
            $display("sbus_frame_receiver_unit regression: fail");
        $finish;
    end

endmodule
